// ===== src/matrix4_inverse_unit_macros.svh =====
// Assertion macros for the 4x4 matrix inverse unit.
`ifndef MATRIX4_INVERSE_UNIT_MACROS_SVH
`define MATRIX4_INVERSE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MI4_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mi4 check failed");

// next-cycle implication, sampled on clk, off during reset
`define MI4_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mi4 check failed");

`endif

// ===== src/mi4_pkg.sv =====
// Shared types, constants and saturation helpers for the 4x4 matrix inverse unit.
`timescale 1ns / 1ps

package mi4_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam logic [3:0] STEP_COF_LAST = 4'd8;
	localparam logic [3:0] STEP_DET      = 4'd9;
	localparam logic [3:0] STEP_TR_FIRST = 4'd10;
	localparam logic [3:0] STEP_TR_LAST  = 4'd12;

	typedef logic [3:0][31:0] row_t;
	typedef logic [2:0][3:0][31:0] rows3_t;

	typedef struct packed {
		logic       mul_en;
		logic [3:0] step;
		logic [1:0] pass;
		logic       div_start;
		logic [1:0] round;
	} lane_ctrl_t;

	typedef struct packed {
		logic [63:0] dq;
		logic [31:0] tr;
		row_t        inv;
		logic        div_done;
	} lane_out_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] neg_sat32(input logic [31:0] d);
		logic [31:0] r;
		if (d == 32'h8000_0000) begin
			r = 32'h7fff_ffff;
		end else begin
			r = ~d + 32'd1;
		end
		return r;
	endfunction

endpackage

// ===== src/matrix4_inverse_unit.sv =====
// Top level of the 4x4 fixed-point matrix inverse unit: row store, sequencer, merge.
`timescale 1ns / 1ps
`include "matrix4_inverse_unit_macros.svh"

// Usage:
// Write in_col0..in_col3 as one matrix row per transaction: a row is taken at
// a rising edge with start high and busy low. Rows 0..3 fill the matrix.
// After the fourth row busy rises while four lanes, one per column, run the
// cofactor multiply-accumulate: 9 products per cofactor row, plus 4 more for
// the determinant and rigid translation. Four lane sums merge into the
// determinant. In general mode each lane then runs 4 restoring divisions of
// 32+FRAC_BITS+1 iterations each on its one-bit-per-cycle divider. Rigid
// mode or a zero determinant skips the division. The four result rows follow
// back to back, each marked by done for one cycle; last_row marks the fourth.
// The receiver cannot stall: results are taken as they appear. busy falls
// with the last row.
// cfg_we writes inverse_mode from cfg_wdata; write it only while idle.
// Reset clears the row count, the sequencer and inverse_mode (general mode).

module matrix4_inverse_unit #(
	parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] in_col0,
	input  logic [31:0] in_col1,
	input  logic [31:0] in_col2,
	input  logic [31:0] in_col3,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output logic        done,
	output logic [1:0]  out_row,
	output logic [31:0] out_col0,
	output logic [31:0] out_col1,
	output logic [31:0] out_col2,
	output logic [31:0] out_col3,
	output logic [31:0] det_value,
	output logic        singular,
	output logic        last_row
);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_CALC  = 3'd1;
	localparam logic [2:0] S_DET   = 3'd2;
	localparam logic [2:0] S_CHK   = 3'd3;
	localparam logic [2:0] S_DIVST = 3'd4;
	localparam logic [2:0] S_DIVW  = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	logic [2:0]  state_q;
	logic [1:0]  row_cnt_q;
	logic [3:0]  step_q;
	logic [1:0]  pass_q;
	logic [1:0]  round_q;
	logic [1:0]  out_cnt_q;
	logic        mode_q;
	logic        sing_q;
	logic [31:0] det_q;
	logic        done_q;

	mi4_pkg::row_t       row_q [4];
	mi4_pkg::rows3_t     grows;
	mi4_pkg::lane_ctrl_t ctrl;
	mi4_pkg::lane_out_t  lo [4];
	mi4_pkg::row_t       out_sel;

	logic signed [63:0] det_sum;
	logic [3:0]         last_step;

	assign busy = state_q != S_LOAD;

	always_comb begin
		grows[0] = (pass_q == 2'd0) ? row_q[1] : row_q[0];
		grows[1] = (pass_q <= 2'd1) ? row_q[2] : row_q[1];
		grows[2] = (pass_q <= 2'd2) ? row_q[3] : row_q[2];
		ctrl.mul_en    = state_q == S_CALC;
		ctrl.step      = step_q;
		ctrl.pass      = pass_q;
		ctrl.div_start = state_q == S_DIVST;
		ctrl.round     = round_q;
		last_step      = (pass_q == 2'd3) ? mi4_pkg::STEP_TR_LAST : mi4_pkg::STEP_COF_LAST;
		det_sum        = $signed(lo[0].dq) + $signed(lo[1].dq)
			+ $signed(lo[2].dq) + $signed(lo[3].dq);
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		mi4_lane #(
			.FRAC_BITS(FRAC_BITS),
			.LANE     (l)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (ctrl),
			.rows  (grows),
			.det   (det_q),
			.res   (lo[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			row_cnt_q <= '0;
			step_q    <= '0;
			pass_q    <= '0;
			round_q   <= '0;
			out_cnt_q <= '0;
			mode_q    <= 1'b0;
			sing_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			done_q <= state_q == S_OUT;
			case (state_q)
				S_LOAD: begin
					if (start) begin
						row_cnt_q <= row_cnt_q + 2'd1;
						if (row_cnt_q == 2'd3) begin
							state_q <= S_CALC;
							step_q  <= '0;
							pass_q  <= '0;
						end
					end
				end
				S_CALC: begin
					if (step_q == last_step) begin
						step_q <= '0;
						if (pass_q == 2'd3) begin
							state_q <= S_DET;
						end else begin
							pass_q <= pass_q + 2'd1;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_DET: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					sing_q    <= !mode_q && (det_q == '0);
					out_cnt_q <= '0;
					round_q   <= '0;
					state_q   <= (mode_q || det_q == '0) ? S_OUT : S_DIVST;
				end
				S_DIVST: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (lo[0].div_done) begin
						round_q <= round_q + 2'd1;
						state_q <= (round_q == 2'd3) ? S_OUT : S_DIVST;
					end
				end
				S_OUT: begin
					out_cnt_q <= out_cnt_q + 2'd1;
					if (out_cnt_q == 2'd3) begin
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_comb begin
		if (mode_q) begin
			if (out_cnt_q == 2'd3) begin
				out_sel = {ONE, 32'd0, 32'd0, 32'd0};
			end else begin
				out_sel = {lo[out_cnt_q].tr, row_q[2][out_cnt_q],
					row_q[1][out_cnt_q], row_q[0][out_cnt_q]};
			end
		end else if (sing_q) begin
			out_sel = '0;
		end else begin
			out_sel = lo[out_cnt_q].inv;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && start) begin
			row_q[row_cnt_q] <= {in_col3, in_col2, in_col1, in_col0};
		end
		if (state_q == S_DET) begin
			det_q <= mi4_pkg::sat32(det_sum);
		end
		if (state_q == S_OUT) begin
			out_row   <= out_cnt_q;
			out_col0  <= out_sel[0];
			out_col1  <= out_sel[1];
			out_col2  <= out_sel[2];
			out_col3  <= out_sel[3];
			det_value <= det_q;
			singular  <= sing_q;
			last_row  <= out_cnt_q == 2'd3;
		end
	end

	assign done = done_q;

	`MI4_ASSERT_NEXT(a_fourth_row_busy, start && !busy && row_cnt_q == 2'd3, busy)
	`MI4_ASSERT_NEXT(a_rows_back_to_back, done && !last_row, done)
	`MI4_ASSERT_NEXT(a_single_burst, done && last_row, !done)
	`MI4_ASSERT_SAME(a_singular_zero, done && singular, out_col0 == '0 && out_col3 == '0)

endmodule

// ===== src/mi4_div.sv =====
// Restoring divider: rounded, saturated fixed-point quotient of num by den.
`timescale 1ns / 1ps

module mi4_div #(
	parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] result
);

	localparam int NW = 32 + FRAC_BITS + 1;
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] n_q;
	logic [31:0]   d_q;
	logic [31:0]   rem_q;
	logic          neg_q;

	logic [31:0] an;
	logic [31:0] ad;
	logic [32:0] rem_sh;
	logic        ge;
	logic        ovp;
	logic        ovn;

	always_comb begin
		an     = num[31] ? (~num + 32'd1) : num;
		ad     = den[31] ? (~den + 32'd1) : den;
		rem_sh = {rem_q, n_q[NW-1]};
		ge     = rem_sh >= {1'b0, d_q};
		ovp    = |n_q[NW-1:31];
		ovn    = (|n_q[NW-1:32]) || (n_q[31] && (|n_q[30:0]));
		done   = busy_q && (cnt_q == CW'(NW));
		if (neg_q) begin
			result = ovn ? 32'h8000_0000 : (~n_q[31:0] + 32'd1);
		end else begin
			result = ovp ? 32'h7fff_ffff : n_q[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= (NW'(an) << FRAC_BITS) + NW'(ad >> 1);
			d_q   <= ad;
			rem_q <= '0;
			neg_q <= num[31] != den[31];
		end else if (busy_q && !done) begin
			rem_q <= ge ? 32'(rem_sh - {1'b0, d_q}) : rem_sh[31:0];
			n_q   <= {n_q[NW-2:0], ge};
		end
	end

endmodule

// ===== src/mi4_lane.sv =====
// One column lane: cofactor multiply-accumulate sequencer plus its divider.
`timescale 1ns / 1ps

module mi4_lane #(
	parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF,
	parameter int LANE      = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mi4_pkg::lane_ctrl_t ctrl,
	input  mi4_pkg::rows3_t    rows,
	input  logic [31:0]        det,
	output mi4_pkg::lane_out_t res
);

	localparam int CA = (LANE == 0) ? 1 : 0;
	localparam int CB = (LANE <= 1) ? 2 : 1;
	localparam int CC = (LANE <= 2) ? 3 : 2;
	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic [3:0] STEP_TR_FIRST_C = mi4_pkg::STEP_TR_FIRST;

	logic [31:0] x;
	logic [31:0] y;

	logic signed [63:0] prod_s1;
	logic [3:0]         step_s1;
	logic [1:0]         pass_s1;
	logic               en_s1;

	logic signed [63:0] acc_q;
	logic [31:0]        c0_q;
	logic [31:0]        c1_q;
	logic [31:0]        c2_q;
	logic [31:0]        cof_q [4];
	logic [31:0]        inv_q [4];
	logic [63:0]        dq_q;
	logic [31:0]        tr_q;

	logic signed [63:0] qv;
	logic signed [63:0] acc_n;
	logic               is_start;
	logic               is_sub;
	logic [31:0]        cof_sat;
	logic               div_done;
	logic [31:0]        div_res;

	always_comb begin
		case (ctrl.step)
			4'd0:    begin x = rows[1][CB]; y = rows[2][CC]; end
			4'd1:    begin x = rows[1][CC]; y = rows[2][CB]; end
			4'd2:    begin x = rows[1][CC]; y = rows[2][CA]; end
			4'd3:    begin x = rows[1][CA]; y = rows[2][CC]; end
			4'd4:    begin x = rows[1][CA]; y = rows[2][CB]; end
			4'd5:    begin x = rows[1][CB]; y = rows[2][CA]; end
			4'd6:    begin x = rows[0][CA]; y = c0_q; end
			4'd7:    begin x = rows[0][CB]; y = c1_q; end
			4'd8:    begin x = rows[0][CC]; y = c2_q; end
			4'd9:    begin x = rows[0][LANE]; y = cof_q[0]; end
			4'd10:   begin x = rows[0][LANE]; y = rows[0][3]; end
			4'd11:   begin x = rows[1][LANE]; y = rows[1][3]; end
			4'd12:   begin x = rows[2][LANE]; y = rows[2][3]; end
			default: begin x = '0; y = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= ctrl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= $signed(x) * $signed(y);
		step_s1 <= ctrl.step;
		pass_s1 <= ctrl.pass;
	end

	always_comb begin
		qv       = (prod_s1 + HALF) >>> FRAC_BITS;
		is_start = step_s1 inside {4'd0, 4'd2, 4'd4, 4'd6, STEP_TR_FIRST_C};
		is_sub   = step_s1 inside {4'd1, 4'd3, 4'd5};
		acc_n    = (is_start ? 64'sd0 : acc_q) + (is_sub ? -qv : qv);
		cof_sat  = mi4_pkg::sat32(acc_n);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			acc_q <= acc_n;
			case (step_s1)
				4'd1: c0_q <= cof_sat;
				4'd3: c1_q <= cof_sat;
				4'd5: c2_q <= cof_sat;
				mi4_pkg::STEP_COF_LAST:
					cof_q[pass_s1] <= (pass_s1[0] ^ LANE[0]) ?
						mi4_pkg::neg_sat32(cof_sat) : cof_sat;
				mi4_pkg::STEP_DET: dq_q <= qv;
				mi4_pkg::STEP_TR_LAST: tr_q <= mi4_pkg::sat32(-acc_n);
				default: ;
			endcase
		end
		if (div_done) begin
			inv_q[ctrl.round] <= div_res;
		end
	end

	mi4_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctrl.div_start),
		.num   (cof_q[ctrl.round]),
		.den   (det),
		.done  (div_done),
		.result(div_res)
	);

	always_comb begin
		res.dq       = dq_q;
		res.tr       = tr_q;
		res.inv      = {inv_q[3], inv_q[2], inv_q[1], inv_q[0]};
		res.div_done = div_done;
	end

endmodule

// ===== sim/mi4_inverse_checker.sv =====
// Checker for the 4x4 matrix inverse unit: row capture, inverse prediction, result compare.
`timescale 1ns / 1ps

module mi4_inverse_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] in_col0,
	input  logic [31:0] in_col1,
	input  logic [31:0] in_col2,
	input  logic [31:0] in_col3,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        done,
	input  logic [1:0]  out_row,
	input  logic [31:0] out_col0,
	input  logic [31:0] out_col1,
	input  logic [31:0] out_col2,
	input  logic [31:0] out_col3,
	input  logic [31:0] det_value,
	input  logic        singular,
	input  logic        last_row,
	output int          errors,
	output int          pending
);

	localparam int FB = mi4_pkg::FRAC_BITS_DEF;

	typedef struct packed {
		logic [1:0]       row;
		logic [3:0][31:0] cols;
		logic [31:0]      det;
		logic             sing;
		logic             last;
	} inv_row_t;

	inv_row_t          inv_rows_q[$];
	logic signed [31:0] mstore[4][4];
	logic [1:0]        rows_held;
	logic              rigid_mode;
	int                err_cnt;

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic longint fx_mul(input logic signed [31:0] a, input logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return (p + (longint'(1) <<< (FB - 1))) >>> FB;
	endfunction

	function automatic logic signed [31:0] minor_2x2(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic signed [31:0] c, input logic signed [31:0] d);
		return clamp32(fx_mul(a, d) - fx_mul(b, c));
	endfunction

	function automatic logic signed [31:0] cofactor_at(input int i, input int j);
		logic signed [31:0] g[9];
		logic signed [31:0] c0, c1, c2, d;
		int n;
		n = 0;
		for (int r = 0; r < 4; r++) begin
			if (r == i) continue;
			for (int c = 0; c < 4; c++) begin
				if (c == j) continue;
				g[n] = mstore[r][c];
				n++;
			end
		end
		c0 = minor_2x2(g[4], g[5], g[7], g[8]);
		c1 = minor_2x2(g[5], g[3], g[8], g[6]);
		c2 = minor_2x2(g[3], g[4], g[6], g[7]);
		d = clamp32(fx_mul(g[0], c0) + fx_mul(g[1], c1) + fx_mul(g[2], c2));
		return ((i + j) % 2 == 1) ? clamp32(-longint'(d)) : d;
	endfunction

	function automatic logic signed [31:0] fx_div(input logic signed [31:0] num,
		input logic signed [31:0] den);
		longint n, d, s;
		longint unsigned an, ad, q;
		logic neg;
		n = longint'(num) <<< FB;
		d = longint'(den);
		neg = (n < 0) != (d < 0);
		an = (n < 0) ? -n : n;
		ad = (d < 0) ? -d : d;
		q = (an + ad / 2) / ad;
		s = q;
		return clamp32(neg ? -s : s);
	endfunction

	task automatic predict_inverse();
		logic signed [31:0] cof[4][4];
		logic signed [31:0] inv[4][4];
		logic signed [31:0] det;
		longint acc;
		inv_row_t e;
		logic sing;
		sing = 1'b0;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				cof[i][j] = cofactor_at(i, j);
		acc = 0;
		for (int j = 0; j < 4; j++)
			acc += fx_mul(mstore[0][j], cof[0][j]);
		det = clamp32(acc);
		if (rigid_mode) begin
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) begin
					inv[i][k] = mstore[k][i];
					acc += fx_mul(mstore[k][i], mstore[k][3]);
				end
				inv[i][3] = clamp32(-acc);
			end
			inv[3][0] = 0;
			inv[3][1] = 0;
			inv[3][2] = 0;
			inv[3][3] = clamp32(longint'(1) <<< FB);
		end else if (det == 0) begin
			sing = 1'b1;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					inv[i][j] = 0;
		end else begin
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					inv[i][j] = fx_div(cof[j][i], det);
		end
		for (int k = 0; k < 4; k++) begin
			e.row = k[1:0];
			for (int j = 0; j < 4; j++)
				e.cols[j] = inv[k][j];
			e.det = det;
			e.sing = sing;
			e.last = (k == 3);
			inv_rows_q.push_back(e);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		inv_row_t got, want;
		if (!arst_n) begin
			inv_rows_q.delete();
			rows_held <= 2'd0;
			rigid_mode <= 1'b0;
			err_cnt = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				rigid_mode <= cfg_wdata;
			if (start && !busy) begin
				mstore[rows_held][0] = in_col0;
				mstore[rows_held][1] = in_col1;
				mstore[rows_held][2] = in_col2;
				mstore[rows_held][3] = in_col3;
				if (rows_held == 2'd3)
					predict_inverse();
				rows_held <= rows_held + 2'd1;
			end
			if (done) begin
				got.row = out_row;
				got.cols = {out_col3, out_col2, out_col1, out_col0};
				got.det = det_value;
				got.sing = singular;
				got.last = last_row;
				if (inv_rows_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result row %0d det %h", out_row, det_value);
				end else begin
					want = inv_rows_q.pop_front();
					if (got !== want) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("mismatch row exp %0d %h %h %h %h det %h s%b l%b / got %0d %h %h %h %h det %h s%b l%b",
								want.row, want.cols[0], want.cols[1], want.cols[2], want.cols[3],
								want.det, want.sing, want.last,
								got.row, got.cols[0], got.cols[1], got.cols[2], got.cols[3],
								got.det, got.sing, got.last);
					end
				end
			end
			errors <= err_cnt;
			pending <= inv_rows_q.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the 4x4 matrix inverse unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] MAXV = 32'h7fff_ffff;
	localparam logic [31:0] MINV = 32'h8000_0000;
	localparam logic MODE_GENERAL = 1'b0;
	localparam logic MODE_RIGID = 1'b1;
	localparam int LIMIT = 1000000;

	logic        clk, arst_n, start, busy, cfg_we, cfg_wdata;
	logic [31:0] in_col0, in_col1, in_col2, in_col3;
	logic        done, singular, last_row;
	logic [1:0]  out_row;
	logic [31:0] out_col0, out_col1, out_col2, out_col3, det_value;
	int          errors, pending, gap_pct;
	int          cycles = 0;
	logic [31:0] mat[4][4];

	matrix4_inverse_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_col0(in_col0), .in_col1(in_col1), .in_col2(in_col2), .in_col3(in_col3),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .out_row(out_row),
		.out_col0(out_col0), .out_col1(out_col1), .out_col2(out_col2), .out_col3(out_col3),
		.det_value(det_value), .singular(singular), .last_row(last_row)
	);

	mi4_inverse_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_col0(in_col0), .in_col1(in_col1), .in_col2(in_col2), .in_col3(in_col3),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .out_row(out_row),
		.out_col0(out_col0), .out_col1(out_col1), .out_col2(out_col2), .out_col3(out_col3),
		.det_value(det_value), .singular(singular), .last_row(last_row),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("matrix4_inverse_unit regression: fail");
			$finish;
		end
	end

	function automatic logic [31:0] near(input int unsigned span);
		return $urandom_range(2 * span, 0) - span;
	endfunction

	task automatic send_matrix();
		int gap;
		for (int r = 0; r < 4; r++) begin
			gap = 0;
			while ($urandom_range(99, 0) < gap_pct)
				gap++;
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			start <= 1'b1;
			in_col0 <= mat[r][0];
			in_col1 <= mat[r][1];
			in_col2 <= mat[r][2];
			in_col3 <= mat[r][3];
			do @(posedge clk); while (busy);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic fill(input logic [31:0] v);
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				mat[r][c] = v;
	endtask

	task automatic diag(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		fill(32'd0);
		mat[0][0] = a;
		mat[1][1] = b;
		mat[2][2] = c;
		mat[3][3] = d;
	endtask

	task automatic rigid_like(input int unsigned tspan);
		int unsigned p;
		int perm[3];
		p = $urandom_range(2, 0);
		perm[0] = p;
		perm[1] = (p + 1 + $urandom_range(1, 0)) % 3;
		perm[2] = 3 - perm[0] - perm[1];
		fill(32'd0);
		for (int r = 0; r < 3; r++) begin
			mat[r][perm[r]] = $urandom_range(1, 0) ? ONE : -ONE;
			mat[r][3] = near(tspan);
		end
		mat[3][3] = ONE;
	endtask

	task automatic random_matrix();
		int unsigned kind;
		kind = $urandom_range(9, 0);
		if (kind < 5) begin
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					mat[r][c] = (r == c) ? ($urandom_range(1, 0) ? 1 : -1) *
						int'($urandom_range(32'h0004_0000, 32'h0000_8000)) : near(32'h0000_8000);
		end else if (kind < 7) begin
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					mat[r][c] = $urandom_range(1, 0) ? $urandom() : near(32'h0010_0000);
		end else if (kind == 7) begin
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					mat[r][c] = near(32'h0003_0000);
			for (int c = 0; c < 4; c++)
				mat[$urandom_range(3, 1)][c] = mat[0][c];
		end else begin
			rigid_like(32'h0100_0000);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_col0 = 32'd0;
		in_col1 = 32'd0;
		in_col2 = 32'd0;
		in_col3 = 32'd0;
		gap_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_mode(MODE_GENERAL);
		diag(ONE, ONE, ONE, ONE);
		send_matrix();
		diag(32'h0002_0000, 32'h0000_8000, 32'h0004_0000, -ONE);
		send_matrix();
		fill(32'd0);
		send_matrix();
		fill(MAXV);
		mat[1][1] = MINV;
		mat[2][0] = MINV;
		mat[3][2] = 32'd0;
		send_matrix();
		drain();
		set_mode(MODE_RIGID);
		fill(32'd0);
		mat[0][1] = -ONE;
		mat[1][0] = ONE;
		mat[2][2] = ONE;
		mat[3][3] = ONE;
		mat[0][3] = 32'h0003_0000;
		mat[1][3] = 32'hfffe_8000;
		mat[2][3] = 32'h0000_0001;
		send_matrix();
		fill(MINV);
		mat[0][3] = MAXV;
		mat[3][0] = MAXV;
		send_matrix();
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: gap_pct = 0;
				1: gap_pct = 85;
				2: gap_pct = 0;
				default: gap_pct = 8;
			endcase
			set_mode((ph % 3 == 0) ? MODE_GENERAL : MODE_RIGID);
			for (int n = 0; n < 15; n++) begin
				random_matrix();
				send_matrix();
			end
			drain();
		end

		if (errors == 0) begin
			$display("matrix4_inverse_unit regression: pass");
		end else begin
			$display("matrix4_inverse_unit regression: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/mi4_pkg.sv
src/mi4_div.sv
src/mi4_lane.sv
src/matrix4_inverse_unit.sv
sim/mi4_inverse_checker.sv
sim/tb.sv
